// ----- hw/rtl/lpft_pkg.sv -----
// Package for the LRU page frame table: sequencer states, status codes,
// register indexes and fixed field widths. No dependencies.

package lpft_pkg;

    // Configuration port
    localparam int CFG_INDEX_BITS    = 8;
    localparam int CFG_DATA_BITS     = 32;
    localparam int PAGE_SIZE_BITS    = 32;
    localparam int TOTAL_FRAMES_BITS = 5;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PAGE_SIZE    = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TOTAL_FRAMES = 8'd1;

    localparam logic [PAGE_SIZE_BITS-1:0]    PAGE_SIZE_RESET    = 32'd4096;
    localparam logic [TOTAL_FRAMES_BITS-1:0] TOTAL_FRAMES_RESET = 5'd16;

    // Result status
    localparam int STATUS_BITS = 2;

    localparam logic [STATUS_BITS-1:0] ST_HIT        = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FREE_LOAD  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EVICT_LOAD = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_NO_PROCESS = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SEARCH,
        S_SHIFT,
        S_PLACE,
        S_DONE
    } lpft_state_t;

endpackage

// ----- hw/rtl/lpft_ifs.sv -----
// Valid/ready channel interfaces for the page frame table: access requests,
// results and configuration writes. Depends on lpft_pkg.

interface lpft_req_if
    import lpft_pkg::*;
#(
    parameter int ADDRESS_BITS = 32,
    parameter int PROCESS_BITS = 16
);
    logic                    valid;
    logic                    ready;
    logic [PROCESS_BITS-1:0] process_id;
    logic [ADDRESS_BITS-1:0] address;

    modport source (output valid, output process_id, output address, input ready);
    modport sink   (input valid, input process_id, input address, output ready);
endinterface

interface lpft_rsp_if
    import lpft_pkg::*;
#(
    parameter int ADDRESS_BITS = 32,
    parameter int PROCESS_BITS = 16,
    parameter int FRAME_BITS   = 4
);
    logic                    valid;
    logic                    ready;
    logic [STATUS_BITS-1:0]  status;
    logic [FRAME_BITS-1:0]   frame;
    logic [ADDRESS_BITS-1:0] page_number;
    logic [ADDRESS_BITS-1:0] evicted_page;
    logic [PROCESS_BITS-1:0] evicted_process;

    modport source (output valid, output status, output frame, output page_number,
                    output evicted_page, output evicted_process, input ready);
    modport sink   (input valid, input status, input frame, input page_number,
                    input evicted_page, input evicted_process, output ready);
endinterface

interface lpft_cfg_if
    import lpft_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/lru_page_frame_table.sv -----
// Top level of the LRU page frame table.
// Depends on lpft_pkg, lpft_ifs, lpft_ram and lpft_div.
//
// Usage:
//   req : one item per memory access (process_id, address).
//   rsp : one item per access (status, frame, page_number, evicted_page,
//         evicted_process).
//   cfg : register writes, index 0 page_size, index 1 total_frames; other
//         indexes are dropped. Always ready; write only while the block is idle.
// One access is in flight at a time; req.ready is high only when idle.
// An access with process id 0 returns status 3, with no state change.
// Otherwise the bit-serial divider first finds the page number, then the
// entry RAM does the rest: one entry a cycle for the search, one a cycle to
// close the gap left by the hit or evicted entry, and one write for the load.
// The result waits in an output register; the next access is taken while
// it waits, and stalls only at its own result if rsp is still held.
// Reset empties the table (resident count and free frame counter to zero) and
// loads page_size 4096, total_frames 16. No clearing pass is needed.

module lru_page_frame_table
    import lpft_pkg::*;
#(
    parameter int FRAMES       = 16,
    parameter int ADDRESS_BITS = 32,
    parameter int PROCESS_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    lpft_cfg_if.sink      cfg,
    lpft_req_if.sink      req,
    lpft_rsp_if.source    rsp
);

    localparam int IDX_BITS  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_BITS  = $clog2(FRAMES + 1);
    localparam int FR_LO     = 0;
    localparam int PID_LO    = IDX_BITS;
    localparam int PG_LO     = IDX_BITS + PROCESS_BITS;
    localparam int WORD_BITS = ADDRESS_BITS + PROCESS_BITS + IDX_BITS;

    lpft_state_t state_reg, state_next;

    logic [PAGE_SIZE_BITS-1:0]    page_size_reg;
    logic [TOTAL_FRAMES_BITS-1:0] total_frames_reg;

    logic [CNT_BITS-1:0] count_reg;
    logic [IDX_BITS-1:0] next_free_reg;
    logic [CNT_BITS-1:0] scan_reg;
    logic [CNT_BITS-1:0] src_reg;
    logic [IDX_BITS-1:0] dst_reg;
    logic [IDX_BITS-1:0] place_reg;
    logic                wpend_reg;

    logic [PROCESS_BITS-1:0] pid_reg;
    logic [ADDRESS_BITS-1:0] page_reg;
    logic [WORD_BITS-1:0]    head_reg;
    logic [STATUS_BITS-1:0]  status_reg;
    logic [IDX_BITS-1:0]     frame_reg;
    logic [ADDRESS_BITS-1:0] ev_page_reg;
    logic [PROCESS_BITS-1:0] ev_proc_reg;

    logic                    rsp_valid_reg;
    logic [STATUS_BITS-1:0]  rsp_status_reg;
    logic [IDX_BITS-1:0]     rsp_frame_reg;
    logic [ADDRESS_BITS-1:0] rsp_page_reg;
    logic [ADDRESS_BITS-1:0] rsp_ev_page_reg;
    logic [PROCESS_BITS-1:0] rsp_ev_proc_reg;

    logic                    req_accept;
    logic                    req_idle_cpu;
    logic                    div_start;
    logic                    div_done;
    logic [ADDRESS_BITS-1:0] div_quotient;

    logic                 ram_we;
    logic [IDX_BITS-1:0]  ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [IDX_BITS-1:0]  ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [WORD_BITS-1:0] head_word;

    logic [CNT_BITS-1:0] limit;
    logic                search_hit;
    logic                search_miss;
    logic                table_full;
    logic                shift_last;
    logic                rsp_load;

    // ---------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_size_reg    <= PAGE_SIZE_RESET;
            total_frames_reg <= TOTAL_FRAMES_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_PAGE_SIZE)
            begin
                page_size_reg <= cfg.data[PAGE_SIZE_BITS-1:0];
            end
            else if (cfg.index == CFG_TOTAL_FRAMES)
            begin
                total_frames_reg <= cfg.data[TOTAL_FRAMES_BITS-1:0];
            end
        end
    end

    // Frame limit: zero acts as one, anything above the depth as the depth
    assign limit = (total_frames_reg == '0) ? CNT_BITS'(1) :
                   ((32'(total_frames_reg) > FRAMES) ? CNT_BITS'(FRAMES) :
                                                      CNT_BITS'(total_frames_reg));

    // ---------------------------------------------------------------
    // Shared units
    // ---------------------------------------------------------------
    lpft_div #(
        .DIVIDEND_BITS (ADDRESS_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (req.address),
        .divisor  (page_size_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Entry word: {page, process, frame}, slot 0 least recent
    lpft_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (FRAMES)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Decisions
    // ---------------------------------------------------------------
    assign req_accept   = req.valid && req.ready;
    assign req_idle_cpu = (req.process_id == '0);

    // Read data is registered and lags the scan index: it belongs to slot scan_reg - 1
    assign search_hit  = (state_reg == S_SEARCH) && (scan_reg != '0) &&
                         (ram_rdata[PG_LO +: ADDRESS_BITS] == page_reg) &&
                         (ram_rdata[PID_LO +: PROCESS_BITS] == pid_reg);
    assign search_miss = (state_reg == S_SEARCH) && !search_hit && (scan_reg == count_reg);
    assign table_full  = (count_reg >= limit);
    assign head_word   = (scan_reg == CNT_BITS'(1)) ? ram_rdata : head_reg;
    assign shift_last  = !(src_reg < count_reg);
    assign rsp_load    = (state_reg == S_DONE) && (!rsp_valid_reg || rsp.ready);

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = req_idle_cpu ? S_DONE : S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (search_hit || (search_miss && table_full))
                begin
                    state_next = S_SHIFT;
                end
                else if (search_miss)
                begin
                    state_next = S_PLACE;
                end
            end
            S_SHIFT:
            begin
                if (shift_last)
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: outputs
    // ---------------------------------------------------------------
    always_comb
    begin
        req.ready = 1'b0;
        div_start = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = place_reg;
        ram_wdata = {page_reg, pid_reg, frame_reg};
        ram_raddr = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                div_start = req.valid && !req_idle_cpu;
            end
            S_SEARCH:
            begin
                ram_raddr = scan_reg[IDX_BITS-1:0];
            end
            S_SHIFT:
            begin
                ram_raddr = src_reg[IDX_BITS-1:0];
                ram_we    = wpend_reg;
                ram_waddr = dst_reg;
                ram_wdata = ram_rdata;
            end
            S_PLACE:
            begin
                ram_we = 1'b1;
            end
            S_DIV, S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            next_free_reg <= '0;
            scan_reg      <= '0;
            src_reg       <= '0;
            dst_reg       <= '0;
            place_reg     <= '0;
            wpend_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (div_done)
            begin
                scan_reg <= '0;
            end
            else if (state_reg == S_SEARCH)
            begin
                scan_reg <= scan_reg + CNT_BITS'(1);
            end

            if (search_hit)
            begin
                src_reg   <= scan_reg;
                dst_reg   <= IDX_BITS'(scan_reg - CNT_BITS'(1));
                wpend_reg <= 1'b0;
                place_reg <= IDX_BITS'(count_reg - CNT_BITS'(1));
            end
            else if (search_miss)
            begin
                src_reg   <= CNT_BITS'(1);
                dst_reg   <= '0;
                wpend_reg <= 1'b0;
                place_reg <= table_full ? IDX_BITS'(count_reg - CNT_BITS'(1))
                                        : IDX_BITS'(count_reg);
            end
            else if (state_reg == S_SHIFT)
            begin
                if (wpend_reg)
                begin
                    dst_reg <= dst_reg + IDX_BITS'(1);
                end
                if (!shift_last)
                begin
                    src_reg <= src_reg + CNT_BITS'(1);
                end
                wpend_reg <= !shift_last;
            end

            if ((state_reg == S_PLACE) && (status_reg == ST_FREE_LOAD))
            begin
                count_reg <= count_reg + CNT_BITS'(1);
                if (next_free_reg == IDX_BITS'(FRAMES - 1))
                begin
                    next_free_reg <= '0;
                end
                else
                begin
                    next_free_reg <= next_free_reg + IDX_BITS'(1);
                end
            end

            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            pid_reg <= req.process_id;
            if (req_idle_cpu)
            begin
                status_reg  <= ST_NO_PROCESS;
                frame_reg   <= '0;
                page_reg    <= '0;
                ev_page_reg <= '0;
                ev_proc_reg <= '0;
            end
        end

        if (div_done)
        begin
            page_reg <= div_quotient;
        end

        if ((state_reg == S_SEARCH) && (scan_reg == CNT_BITS'(1)))
        begin
            head_reg <= ram_rdata;
        end

        if (search_hit)
        begin
            status_reg  <= ST_HIT;
            frame_reg   <= ram_rdata[FR_LO +: IDX_BITS];
            ev_page_reg <= '0;
            ev_proc_reg <= '0;
        end
        else if (search_miss && table_full)
        begin
            status_reg  <= ST_EVICT_LOAD;
            frame_reg   <= head_word[FR_LO +: IDX_BITS];
            ev_page_reg <= head_word[PG_LO +: ADDRESS_BITS];
            ev_proc_reg <= head_word[PID_LO +: PROCESS_BITS];
        end
        else if (search_miss)
        begin
            status_reg  <= ST_FREE_LOAD;
            frame_reg   <= next_free_reg;
            ev_page_reg <= '0;
            ev_proc_reg <= '0;
        end

        if (rsp_load)
        begin
            rsp_status_reg  <= status_reg;
            rsp_frame_reg   <= frame_reg;
            rsp_page_reg    <= page_reg;
            rsp_ev_page_reg <= ev_page_reg;
            rsp_ev_proc_reg <= ev_proc_reg;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = rsp_status_reg;
    assign rsp.frame           = rsp_frame_reg;
    assign rsp.page_number     = rsp_page_reg;
    assign rsp.evicted_page    = rsp_ev_page_reg;
    assign rsp.evicted_process = rsp_ev_proc_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(FRAMES))
        else $error("resident count above table depth");

    a_free_load_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PLACE) && (status_reg == ST_FREE_LOAD)
        |=> count_reg == $past(count_reg) + CNT_BITS'(1))
        else $error("free-frame load did not grow the table");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide phase");

    a_idle_cpu_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == ST_NO_PROCESS)
        |-> (rsp.frame == '0) && (rsp.evicted_process == '0) && (rsp.page_number == '0))
        else $error("idle-cpu result carries non-zero fields");

endmodule

// ----- hw/rtl/lpft_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module lpft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/lpft_div.sv -----
// Restoring divider, one quotient bit per cycle, for the page number.
// Depends on lpft_pkg for the divisor width.

module lpft_div
    import lpft_pkg::*;
#(
    parameter int DIVIDEND_BITS = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [DIVIDEND_BITS-1:0]  dividend,
    input  logic [PAGE_SIZE_BITS-1:0] divisor,
    output logic                      done,
    output logic [DIVIDEND_BITS-1:0]  quotient
);

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

    logic                      busy_reg;
    logic                      done_reg;
    logic [CNT_BITS-1:0]       cnt_reg;
    logic [PAGE_SIZE_BITS-1:0] rem_reg;
    logic [PAGE_SIZE_BITS-1:0] rem_next;
    logic [PAGE_SIZE_BITS-1:0] dvs_reg;
    logic [DIVIDEND_BITS-1:0]  quo_reg;
    logic [PAGE_SIZE_BITS:0]   trial;
    logic [PAGE_SIZE_BITS:0]   diff;
    logic                      qbit;

    // A zero divisor always passes the compare, so the quotient comes out all ones.
    assign trial    = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign qbit     = (trial >= {1'b0, dvs_reg});
    assign rem_next = qbit ? diff[PAGE_SIZE_BITS-1:0] : trial[PAGE_SIZE_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(DIVIDEND_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_BITS-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- sim/lpft_access_checker.sv -----
// Checker for the LRU page frame table: watches the cfg, req and rsp channels,
// predicts each access result and compares it with what the block returns.
// Depends on lpft_pkg and lpft_ifs.
`timescale 1ns / 1ps

module lpft_access_checker
    import lpft_pkg::*;
#(
    parameter int FRAMES = 16
) (
    input  logic   clk,
    input  logic   rst_n,
    lpft_cfg_if    cfg,
    lpft_req_if    req,
    lpft_rsp_if    rsp,
    output int     fault_count,
    output int     lookups_in_flight
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [3:0]             frame;
        logic [31:0]            page_number;
        logic [31:0]            evicted_page;
        logic [15:0]            evicted_process;
    } lookup_result_t;

    logic [PAGE_SIZE_BITS-1:0]    page_size;
    logic [TOTAL_FRAMES_BITS-1:0] total_frames;

    // resident pages, slot 0 least recently used
    logic [31:0] slot_page    [FRAMES];
    logic [15:0] slot_process [FRAMES];
    logic [3:0]  slot_frame   [FRAMES];
    int          resident;
    logic [3:0]  next_free;

    lookup_result_t pending_lookups [$];

    task automatic drop_slot(input int idx);
        for (int i = idx; i + 1 < resident; i++)
        begin
            slot_page[i]    = slot_page[i + 1];
            slot_process[i] = slot_process[i + 1];
            slot_frame[i]   = slot_frame[i + 1];
        end
    endtask

    task automatic store_slot(input int idx, input logic [31:0] pg, input logic [15:0] pid,
                              input logic [3:0] fr);
        slot_page[idx]    = pg;
        slot_process[idx] = pid;
        slot_frame[idx]   = fr;
    endtask

    task automatic lookup_page(input logic [15:0] pid, input logic [31:0] addr,
                               output lookup_result_t res);
        int          limit;
        int          hit_slot;
        logic [31:0] pg;
        res = '0;
        if (pid == '0)
        begin
            res.status = ST_NO_PROCESS;
            return;
        end
        // zero divisor gives all ones
        pg = (page_size == '0) ? '1 : addr / page_size;
        if (total_frames == '0)
            limit = 1;
        else if (int'(total_frames) > FRAMES)
            limit = FRAMES;
        else
            limit = int'(total_frames);
        hit_slot = -1;
        for (int i = 0; i < resident; i++)
            if (hit_slot < 0 && slot_page[i] == pg && slot_process[i] == pid)
                hit_slot = i;
        res.page_number = pg;
        if (hit_slot >= 0)
        begin
            res.status = ST_HIT;
            res.frame  = slot_frame[hit_slot];
            drop_slot(hit_slot);
            store_slot(resident - 1, pg, pid, res.frame);
        end
        else if (resident >= limit)
        begin
            // limit may sit below the count: only one entry goes
            res.status          = ST_EVICT_LOAD;
            res.frame           = slot_frame[0];
            res.evicted_page    = slot_page[0];
            res.evicted_process = slot_process[0];
            drop_slot(0);
            store_slot(resident - 1, pg, pid, res.frame);
        end
        else
        begin
            res.status = ST_FREE_LOAD;
            res.frame  = next_free;
            store_slot(resident, pg, pid, next_free);
            resident  = resident + 1;
            next_free = next_free + 1'b1;
        end
    endtask

    always @(posedge clk)
    begin
        lookup_result_t predicted;
        lookup_result_t seen;
        if (!rst_n)
        begin
            page_size         = PAGE_SIZE_RESET;
            total_frames      = TOTAL_FRAMES_RESET;
            resident          = 0;
            next_free         = '0;
            fault_count       = 0;
            lookups_in_flight = 0;
            pending_lookups.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_PAGE_SIZE:    page_size    = cfg.data[PAGE_SIZE_BITS-1:0];
                    CFG_TOTAL_FRAMES: total_frames = cfg.data[TOTAL_FRAMES_BITS-1:0];
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
            begin
                lookup_page(req.process_id, req.address, predicted);
                pending_lookups.insert(pending_lookups.size(), predicted);
            end
            if (rsp.valid && rsp.ready)
            begin
                seen = '{rsp.status, rsp.frame, rsp.page_number, rsp.evicted_page,
                         rsp.evicted_process};
                if (pending_lookups.size() == 0)
                begin
                    fault_count = fault_count + 1;
                    if (fault_count <= REPORT_LIMIT)
                        $display("%0t: unexpected result status %0d frame %0d page %h",
                                 $realtime, seen.status, seen.frame, seen.page_number);
                end
                else
                begin
                    predicted = pending_lookups[0];
                    pending_lookups.delete(0);
                    if (seen.status !== predicted.status
                        || seen.frame !== predicted.frame
                        || seen.page_number !== predicted.page_number
                        || seen.evicted_page !== predicted.evicted_page
                        || seen.evicted_process !== predicted.evicted_process)
                    begin
                        fault_count = fault_count + 1;
                        if (fault_count <= REPORT_LIMIT)
                            $display("%0t: mismatch (exp/got) status %0d/%0d frame %0d/%0d",
                                     $realtime, predicted.status, seen.status,
                                     predicted.frame, seen.frame,
                                     " page %h/%h evicted page %h/%h process %h/%h",
                                     predicted.page_number, seen.page_number,
                                     predicted.evicted_page, seen.evicted_page,
                                     predicted.evicted_process, seen.evicted_process);
                    end
                end
            end
            lookups_in_flight = pending_lookups.size();
        end
    end

endmodule

// ----- sim/lru_page_frame_table_tb.sv -----
// Testbench top for the LRU page frame table: clock, reset, access and
// register stimulus, and the verdict. Depends on lpft_pkg, lpft_ifs,
// lru_page_frame_table and lpft_access_checker.
`timescale 1ns / 1ps

module lru_page_frame_table_tb
    import lpft_pkg::*;
;

    localparam int IDLE_PERCENT = 7;
    localparam int POOL_PIDS    = 3;
    localparam int POOL_PAGES   = 32;
    localparam int PHASE_ITEMS  = 110;
    localparam int TAIL_CYCLES  = 100;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_FIRST_SPARE = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LAST_SPARE  = 8'd255;

    logic clk;
    logic rst_n;
    bit   steady_traffic;
    int   fault_count;
    int   lookups_in_flight;

    logic [31:0] cur_page_size;
    logic [15:0] pool_pid  [POOL_PIDS];
    logic [31:0] pool_page [POOL_PAGES];

    lpft_req_if req_ch ();
    lpft_rsp_if rsp_ch ();
    lpft_cfg_if cfg_ch ();

    lru_page_frame_table u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    lpft_access_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_ch),
        .req               (req_ch),
        .rsp               (rsp_ch),
        .fault_count       (fault_count),
        .lookups_in_flight (lookups_in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    // result side back-pressure
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= steady_traffic || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    task automatic issue_access(input logic [15:0] pid, input logic [31:0] addr);
        @(negedge clk);
        while (!steady_traffic && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.process_id <= pid;
        req_ch.address    <= addr;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic drain_lookups();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (lookups_in_flight != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_PAGE_SIZE)
            cur_page_size = value;
    endtask

    // a byte address that lands on page pg (folded into range) at the current page size
    function automatic logic [31:0] page_address(input logic [31:0] pg);
        logic [63:0] last_page;
        logic [63:0] base;
        logic [63:0] offset;
        if (cur_page_size == '0)
            return $urandom;
        last_page = 64'(32'hFFFF_FFFF / cur_page_size);
        base      = (64'(pg) % (last_page + 1)) * 64'(cur_page_size);
        offset    = {$urandom, $urandom} % 64'(cur_page_size);
        if (base + offset > 64'h0000_0000_FFFF_FFFF)
            offset = '0;
        return 32'(base + offset);
    endfunction

    // mostly reuse of a small working set, with idle-CPU and raw noise mixed in
    task automatic run_phase(input int count, input int pages);
        int          roll;
        logic [15:0] pid;
        for (int i = 0; i < POOL_PIDS; i++)
        begin
            pool_pid[i] = 16'($urandom);
            if (pool_pid[i] == '0)
                pool_pid[i] = 16'd1;
        end
        for (int i = 0; i < pages; i++)
            pool_page[i] = $urandom;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
                issue_access(16'($urandom), $urandom);
            else if (roll < 12)
                issue_access('0, $urandom);
            else
            begin
                pid = pool_pid[$urandom_range(0, POOL_PIDS - 1)];
                issue_access(pid, page_address(pool_page[$urandom_range(0, pages - 1)]));
            end
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        steady_traffic    = 1'b0;
        cur_page_size     = PAGE_SIZE_RESET;
        req_ch.valid      = 1'b0;
        req_ch.process_id = '0;
        req_ch.address    = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: idle CPU, free loads, hits, same page other process, then fill and evict
        issue_access('0, 32'hFFFF_FFFF);
        issue_access(16'hFFFF, 32'hFFFF_FFFF);
        issue_access(16'd1, 32'h0000_0000);
        issue_access(16'd1, 32'h0000_0FFF);
        issue_access(16'hFFFF, 32'hFFFF_F000);
        issue_access(16'd2, 32'h0000_0000);
        issue_access('0, 32'h0000_0000);
        for (int k = 0; k < 14; k++)
            issue_access(16'd3, 32'(k) * 32'd4096 + 32'd5);
        issue_access(16'd1, 32'h0000_0010);
        issue_access(16'h8000, 32'h8000_0000);
        drain_lookups();

        write_reg(CFG_PAGE_SIZE, 32'd1);
        write_reg(CFG_TOTAL_FRAMES, 32'd4);
        run_phase(PHASE_ITEMS, 8);

        drain_lookups();
        write_reg(CFG_PAGE_SIZE, 32'd0);
        write_reg(CFG_TOTAL_FRAMES, 32'd1);
        run_phase(PHASE_ITEMS, 4);

        // fill the table without any idling
        drain_lookups();
        write_reg(CFG_PAGE_SIZE, 32'($urandom_range(16, 256)));
        write_reg(CFG_TOTAL_FRAMES, 32'd31);
        steady_traffic = 1'b1;
        run_phase(PHASE_ITEMS, 24);
        steady_traffic = 1'b0;

        // limit well below the resident count
        drain_lookups();
        write_reg(CFG_PAGE_SIZE, 32'hFFFF_FFFF);
        write_reg(CFG_TOTAL_FRAMES, 32'd5);
        run_phase(PHASE_ITEMS, 4);

        drain_lookups();
        write_reg(CFG_PAGE_SIZE, $urandom);
        write_reg(CFG_TOTAL_FRAMES, 32'd0);
        run_phase(PHASE_ITEMS, 3);

        drain_lookups();
        write_reg(CFG_PAGE_SIZE, 32'd4096);
        write_reg(CFG_TOTAL_FRAMES, 32'd17);
        write_reg(8'($urandom_range(CFG_FIRST_SPARE, CFG_LAST_SPARE)), $urandom);
        run_phase(PHASE_ITEMS, 20);

        drain_lookups();
        write_reg(CFG_PAGE_SIZE, 32'($urandom_range(1, 64)));
        write_reg(CFG_TOTAL_FRAMES, 32'($urandom_range(2, 15)));
        write_reg(CFG_LAST_SPARE, $urandom);
        run_phase(PHASE_ITEMS, 12);

        drain_lookups();
        write_reg(CFG_PAGE_SIZE, PAGE_SIZE_RESET);
        write_reg(CFG_TOTAL_FRAMES, 32'(TOTAL_FRAMES_RESET));
        run_phase(PHASE_ITEMS, 30);

        drain_lookups();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fault_count == 0 && lookups_in_flight == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
